>>> rtl/cv3_pkg.sv
// ----------------------------------------------------------------------------
// cv3_pkg - shared types and constants of the 3x3 convolution unit
// Register indexes, reset values, fixed-point format and the structs that
// travel into and out of the multiply-accumulate stage.
// ----------------------------------------------------------------------------
package cv3_pkg;

  // Largest supported row length (line buffer depth)
  localparam int MaxWidth     = 2048;
  // Fraction bits of the coefficients and of the filtered value
  localparam int CoefFracBits = 8;
  // Largest row count that the frame counter handles
  localparam int HeightCap    = 65534;
  // Result queue depth (power of two)
  localparam int OutDepth     = 8;

  localparam int PixW   = 8;
  localparam int CoefW  = 16;
  localparam int ProdW  = PixW + 1 + CoefW;
  localparam int SumW   = ProdW + 4;
  localparam int ValueW = 28;
  localparam int KRowW  = 3 * CoefW;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4
  } cfg_reg_e;

  localparam logic [11:0]      WidthReset     = 12'd640;
  localparam logic [15:0]      HeightReset    = 16'd480;
  localparam logic [KRowW-1:0] KernelTopReset = 48'h0100_0000_FF00;
  localparam logic [KRowW-1:0] KernelMidReset = 48'h0200_0000_FE00;
  localparam logic [KRowW-1:0] KernelBotReset = 48'h0100_0000_FF00;

  // Nine selected window pixels, index row*3 + column
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [8:0][PixW-1:0] px;
  } cv3_taps_t;

  // Finished result plus the number of requests still in the MAC pipe
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ValueW-1:0] value;
    logic [PixW-1:0]   magnitude;
    logic [1:0]        inflight;
  } cv3_res_t;

endpackage

>>> rtl/cv3_ram.sv
// ----------------------------------------------------------------------------
// cv3_ram - generic simple dual-port RAM
// One write port, one read port, registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module cv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cv3_mac.sv
// ----------------------------------------------------------------------------
// cv3_mac - nine-tap multiply-accumulate with magnitude rounding
// Stage one registers the nine products, stage two the sum; the magnitude
// is rounded to nearest (ties to even) and saturated on the way out.
// ----------------------------------------------------------------------------
module cv3_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cv3_pkg::cv3_taps_t                taps_i,
  input  logic [2:0][cv3_pkg::KRowW-1:0]    kernel_i,
  output cv3_pkg::cv3_res_t                 res_o
);

  localparam int F  = cv3_pkg::CoefFracBits;
  localparam int SW = cv3_pkg::SumW;
  localparam int QW = SW - F;

  logic signed [cv3_pkg::ProdW-1:0] prod_d [9];
  logic signed [cv3_pkg::ProdW-1:0] prod_q [9];
  logic                             p_valid_q, p_last_q;
  logic signed [SW-1:0]             sum_d, sum_q;
  logic                             s_valid_q, s_last_q;
  logic [SW-1:0]                    mag;
  logic [QW-1:0]                    quo;
  logic [F-1:0]                     rem;
  logic                             round_up;
  logic [QW:0]                      quo_rnd;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[k*3+j] = $signed({1'b0, taps_i.px[k*3+j]})
                      * $signed(kernel_i[k][cv3_pkg::CoefW*j +: cv3_pkg::CoefW]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      p_valid_q <= taps_i.valid;
      s_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    p_last_q <= taps_i.last;
    sum_q    <= sum_d;
    s_last_q <= p_last_q;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 9; i++) begin
      sum_d = sum_d + SW'(prod_q[i]);
    end
  end

  // Round half to even, then clamp to eight bits
  always_comb begin
    mag      = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
    quo      = mag[SW-1:F];
    rem      = mag[F-1:0];
    round_up = (rem > {1'b1, {(F-1){1'b0}}})
            || ((rem == {1'b1, {(F-1){1'b0}}}) && quo[0]);
    quo_rnd  = {1'b0, quo} + (QW+1)'(round_up);
  end

  always_comb begin
    res_o.valid     = s_valid_q;
    res_o.last      = s_last_q;
    res_o.value     = sum_q[cv3_pkg::ValueW-1:0];
    res_o.magnitude = (quo_rnd > (QW+1)'(255)) ? 8'hFF : quo_rnd[7:0];
    res_o.inflight  = {1'b0, p_valid_q} + {1'b0, s_valid_q};
  end

endmodule

>>> rtl/conv2d_3x3_reflect_border_unit.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_reflect_border_unit - 3x3 convolution with reflect-101 border
// Raster-order 8-bit pixels in, signed Q.8 filtered values and a rounded
// 8-bit magnitude out, one row plus one pixel behind the input.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | tdata: pixel; tuser: opcode
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | tdata: value, magnitude;
//          |           |                            | tlast: frame_last
//  cfg     | in        | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// One request per clock while the result queue has room: the line buffer
// RAM is read at accept and written in the next cycle, so the read-write
// path through the RAM port sets the rate. On its way to the head of the
// result queue a request passes the RAM read, the products and the sum.
// Reset clears counters and queue; the line buffer is not cleared since
// border mirroring never reads stale rows. A stalled output keeps accepting
// until the eight-entry result queue, counted with requests in flight, fills.
// ----------------------------------------------------------------------------
module conv2d_3x3_reflect_border_unit #(
  parameter int MAX_WIDTH = cv3_pkg::MaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [27:0] filtered_value, [35:28] magnitude
  output logic        m_axis_tlast,   // frame_last
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = AW + 1;
  localparam int WX  = (CW > 12) ? CW : 12;
  localparam int QAW = $clog2(cv3_pkg::OutDepth);
  localparam int EW  = 1 + cv3_pkg::PixW + cv3_pkg::ValueW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [11:0]                     width_q;
  logic [15:0]                     height_q;
  logic [2:0][cv3_pkg::KRowW-1:0]  kernel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= cv3_pkg::WidthReset;
      height_q    <= cv3_pkg::HeightReset;
      kernel_q[0] <= cv3_pkg::KernelTopReset;
      kernel_q[1] <= cv3_pkg::KernelMidReset;
      kernel_q[2] <= cv3_pkg::KernelBotReset;
    end else if (cfg_we_i) begin
      case (cv3_pkg::cfg_reg_e'(cfg_index_i))
        cv3_pkg::CFG_IMAGE_WIDTH:   width_q     <= cfg_wdata_i[11:0];
        cv3_pkg::CFG_IMAGE_HEIGHT:  height_q    <= cfg_wdata_i[15:0];
        cv3_pkg::CFG_KERNEL_TOP:    kernel_q[0] <= cfg_wdata_i;
        cv3_pkg::CFG_KERNEL_MIDDLE: kernel_q[1] <= cfg_wdata_i;
        cv3_pkg::CFG_KERNEL_BOTTOM: kernel_q[2] <= cfg_wdata_i;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Effective frame size, clamped to the supported range
  logic [WX-1:0] width_x;
  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  logic [16:0]   h_p1;

  always_comb begin
    width_x = WX'(width_q);
    if (width_x < WX'(2)) begin
      w_eff = CW'(2);
    end else if (width_x > WX'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = width_x[CW-1:0];
    end
    if (height_q < 16'd2) begin
      h_eff = 16'd2;
    end else if (height_q > 16'(cv3_pkg::HeightCap)) begin
      h_eff = 16'(cv3_pkg::HeightCap);
    end else begin
      h_eff = height_q;
    end
    h_p1 = {1'b0, h_eff} + 17'd1;
  end

  // --------------------------------------------------------------------------
  // Accept stage: position counters and emit decisions
  // --------------------------------------------------------------------------
  logic [AW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic          in_acc;
  logic          wrap;
  logic [AW-1:0] ic;
  logic [15:0]   ir;
  logic [CW-1:0] ic_inc;
  logic          col0, beyond;
  logic          tail_emit, ctr_emit;
  logic          top_d, bot_d, left_d;
  logic [7:0]    px_d;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    wrap      = {1'b0, col_q} >= w_eff;
    ic        = wrap ? '0 : col_q;
    ir        = wrap ? row_q + 16'd1 : row_q;
    col0      = (ic == '0);
    beyond    = {1'b0, ir} >= h_p1;
    px_d      = s_axis_tuser[0] ? 8'd0 : s_axis_tdata;

    // Right-edge result of the row before last, taken at a row start
    tail_emit = col0 && (ir >= 16'd2);
    // Regular result one row and one column behind
    ctr_emit  = !col0 && (ir >= 16'd1) && (ir <= h_eff);

    if (tail_emit) begin
      top_d = (ir == 16'd2);
      bot_d = beyond;
    end else begin
      top_d = (ir == 16'd1);
      bot_d = (ir >= h_eff);
    end
    left_d = (ic == AW'(1));

    ic_inc = {1'b0, ic} + CW'(1);
    if (col0 && beyond) begin
      col_d = '0;
      row_d = '0;
    end else if (ic_inc >= w_eff) begin
      col_d = '0;
      row_d = ir + 16'd1;
    end else begin
      col_d = ic_inc[AW-1:0];
      row_d = ir;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer: word = {middle line, upper line} at each column
  // --------------------------------------------------------------------------
  logic          s1_valid_q;
  logic [AW-1:0] s1_addr_q;
  logic [7:0]    s1_px_q;
  logic          s1_tail_q, s1_ctr_q, s1_last_q;
  logic          s1_top_q, s1_bot_q, s1_left_q;
  logic          s1_fwd_q;
  logic [15:0]   fwd_q;
  logic [15:0]   ram_rdata;
  logic [15:0]   entry;
  logic [15:0]   wr_entry;

  assign entry    = s1_fwd_q ? fwd_q : ram_rdata;
  assign wr_entry = {s1_px_q, entry[15:8]};

  cv3_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_entry),
    .raddr_i (ic),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
    end
  end

  // Hold request fields; forward the word written this cycle when the
  // new request reads the same column (frame restart on a row start)
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q <= ic;
      s1_px_q   <= px_d;
      s1_tail_q <= tail_emit;
      s1_ctr_q  <= ctr_emit;
      s1_last_q <= beyond;
      s1_top_q  <= top_d;
      s1_bot_q  <= bot_d;
      s1_left_q <= left_d;
      s1_fwd_q  <= s1_valid_q && (s1_addr_q == ic);
      fwd_q     <= wr_entry;
    end
  end

  // --------------------------------------------------------------------------
  // 3x3 window: column 2 is the newest
  // --------------------------------------------------------------------------
  logic [2:0][2:0][7:0] win_q, win_new, win_src;
  logic [2:0][1:0]      rsel, csel;
  cv3_pkg::cv3_taps_t   taps;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_new[r][0] = win_q[r][1];
      win_new[r][1] = win_q[r][2];
    end
    win_new[0][2] = entry[7:0];
    win_new[1][2] = entry[15:8];
    win_new[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win_q <= win_new;
    end
  end

  // Reflect-101 selection. The right edge always comes from the tail result
  // on the old window, so the regular result never mirrors its right column.
  always_comb begin
    rsel[0] = s1_top_q ? 2'd2 : 2'd0;
    rsel[1] = 2'd1;
    rsel[2] = s1_bot_q ? 2'd0 : 2'd2;
    if (s1_tail_q) begin
      win_src = win_q;
      csel[0] = 2'd1;
      csel[1] = 2'd2;
      csel[2] = 2'd1;
    end else begin
      win_src = win_new;
      csel[0] = s1_left_q ? 2'd2 : 2'd0;
      csel[1] = 2'd1;
      csel[2] = 2'd2;
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        taps.px[k*3+j] = win_src[rsel[k]][csel[j]];
      end
    end
    taps.valid = s1_valid_q && (s1_tail_q || s1_ctr_q);
    taps.last  = s1_tail_q && s1_last_q;
  end

  cv3_pkg::cv3_res_t res;

  cv3_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .taps_i   (taps),
    .kernel_i (kernel_q),
    .res_o    (res)
  );

  // --------------------------------------------------------------------------
  // Result queue; accept only while every request in flight has a slot
  // --------------------------------------------------------------------------
  logic [EW-1:0]  queue_q [cv3_pkg::OutDepth];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q, count_d;
  logic [QAW+1:0] committed;
  logic           push, pop;
  logic [EW-1:0]  head;

  assign push      = res.valid;
  assign pop       = m_axis_tvalid && m_axis_tready;
  assign committed = (QAW+2)'(count_q) + (QAW+2)'(taps.valid) + (QAW+2)'(res.inflight);

  assign s_axis_tready = committed < (QAW+2)'(cv3_pkg::OutDepth);

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + (QAW+1)'(1);
    end else if (pop && !push) begin
      count_d = count_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= {res.last, res.magnitude, res.value};
    end
  end

  assign head          = queue_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {4'd0, head[EW-2:0]};
  assign m_axis_tlast  = head[EW-1];

endmodule

>>> rtl/cv3_checker.sv
// ----------------------------------------------------------------------------
// cv3_checker - port-level checks of the 3x3 convolution unit
// Watches the result stream: stall behavior and magnitude consistency.
// ----------------------------------------------------------------------------
module cv3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic signed [27:0] fv;
  logic [7:0]         mag;

  assign fv  = $signed(m_axis_tdata[27:0]);
  assign mag = m_axis_tdata[35:28];

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fv == 28'sd0) |-> (mag == 8'd0))
    else $error("zero value with nonzero magnitude");

  a_sat_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fv >= 28'sd65536) |-> (mag == 8'd255))
    else $error("large positive value not saturated");

  a_sat_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (fv <= -28'sd65536) |-> (mag == 8'd255))
    else $error("large negative value not saturated");

endmodule

bind conv2d_3x3_reflect_border_unit cv3_checker u_cv3_checker (.*);

>>> tb/conv2d_3x3_reflect_border_unit_tb.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_reflect_border_unit_tb - self-checking bench of the 3x3 filter
// Streams raster frames of gray pixels through the unit and checks every
// filtered value, rounded magnitude and end-of-frame flag against a window
// predictor kept in step with the accepted requests. It covers clamped sizes,
// extreme kernels and mid-frame size changes, then random frames with random
// bursts and stalls on both streams.
// ----------------------------------------------------------------------------

typedef enum bit {
  OP_PIXEL = 1'b0,
  OP_DRAIN = 1'b1
} stream_op_e;

// Window predictor plus the queue of filter results still owed by the unit
class conv_window_scoreboard;

  typedef struct {
    logic [cv3_pkg::ValueW-1:0] value;
    logic [cv3_pkg::PixW-1:0]   magnitude;
    logic                       frame_last;
  } filter_result_t;

  bit [7:0]       line_rows [2*cv3_pkg::MaxWidth];
  bit [7:0]       taps [3][3];
  int unsigned    next_col;
  int unsigned    next_row;
  bit [11:0]      width_reg;
  bit [15:0]      height_reg;
  bit [47:0]      kernel_rows [3];
  filter_result_t results_due [$];
  int unsigned    requests;
  int unsigned    drain_ticks;
  int unsigned    results_seen;
  int unsigned    frames_done;
  int unsigned    errors;

  function new();
    foreach (line_rows[i]) line_rows[i] = '0;
    foreach (taps[r, c]) taps[r][c] = '0;
    next_col       = 0;
    next_row       = 0;
    width_reg      = cv3_pkg::WidthReset;
    height_reg     = cv3_pkg::HeightReset;
    kernel_rows[0] = cv3_pkg::KernelTopReset;
    kernel_rows[1] = cv3_pkg::KernelMidReset;
    kernel_rows[2] = cv3_pkg::KernelBotReset;
    requests       = 0;
    drain_ticks    = 0;
    results_seen   = 0;
    frames_done    = 0;
    errors         = 0;
  endfunction

  function void write_reg(logic [2:0] index, logic [47:0] data);
    case (index)
      cv3_pkg::CFG_IMAGE_WIDTH:   width_reg      = data[11:0];
      cv3_pkg::CFG_IMAGE_HEIGHT:  height_reg     = data[15:0];
      cv3_pkg::CFG_KERNEL_TOP:    kernel_rows[0] = data;
      cv3_pkg::CFG_KERNEL_MIDDLE: kernel_rows[1] = data;
      cv3_pkg::CFG_KERNEL_BOTTOM: kernel_rows[2] = data;
      default: ;
    endcase
  endfunction

  function int unsigned frame_width();
    if (width_reg < 2) return 2;
    if (width_reg > cv3_pkg::MaxWidth) return cv3_pkg::MaxWidth;
    return width_reg;
  endfunction

  function int unsigned frame_height();
    if (height_reg < 2) return 2;
    if (height_reg > cv3_pkg::HeightCap) return cv3_pkg::HeightCap;
    return height_reg;
  endfunction

  function bit at_frame_start();
    return next_col == 0 && next_row == 0;
  endfunction

  function void flag(string what);
    errors++;
    $display("%0t: %s", $time, what);
  endfunction

  // Multiply-accumulate around (cr, cc) with reflect-101 tap selection
  function void convolve_window(int unsigned cr, int unsigned cc, bit right_edge, bit last,
                                int unsigned w, int unsigned h);
    int             rsel [3];
    int             csel [3];
    int             acc;
    int unsigned    mag;
    int unsigned    q;
    int unsigned    rem;
    int unsigned    half;
    logic signed [15:0] k;
    filter_result_t res;

    rsel[0] = (cr == 0) ? 2 : 0;
    rsel[1] = 1;
    rsel[2] = (cr >= h - 1) ? 0 : 2;
    if (right_edge) begin
      // window has already moved past the edge: mirror column w-2 around it
      csel[0] = 1;
      csel[1] = 2;
      csel[2] = 1;
    end else begin
      csel[0] = (cc == 0) ? 2 : 0;
      csel[1] = 1;
      csel[2] = (cc >= w - 1) ? 0 : 2;
    end
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k = kernel_rows[r][16*c +: 16];
        acc += int'(taps[rsel[r]][csel[c]]) * int'(k);
      end
    end
    mag  = (acc < 0) ? -acc : acc;
    q    = mag >> cv3_pkg::CoefFracBits;
    rem  = mag & ((1 << cv3_pkg::CoefFracBits) - 1);
    half = 1 << (cv3_pkg::CoefFracBits - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (q > 255) q = 255;
    res.value      = acc[cv3_pkg::ValueW-1:0];
    res.magnitude  = q[7:0];
    res.frame_last = last;
    results_due.push_back(res);
    if (last) frames_done++;
  endfunction

  function void take_pixel_request(stream_op_e op, bit [7:0] pixel);
    int unsigned w;
    int unsigned h;
    int unsigned ic;
    int unsigned ir;
    bit [7:0]    px;
    bit [7:0]    up;
    bit [7:0]    mid;

    w  = frame_width();
    h  = frame_height();
    ic = next_col;
    ir = next_row;
    px = (op == OP_DRAIN) ? 8'd0 : pixel;
    requests++;
    if (op == OP_DRAIN) drain_ticks++;

    if (ic >= w) begin
      ic = 0;
      ir++;
    end
    // right edge of the row before last comes from the window before the shift
    if (ic == 0 && ir >= 2) convolve_window(ir - 2, w - 1, 1'b1, ir >= h + 1, w, h);

    up  = line_rows[ic];
    mid = line_rows[cv3_pkg::MaxWidth + ic];
    for (int r = 0; r < 3; r++) begin
      taps[r][0] = taps[r][1];
      taps[r][1] = taps[r][2];
    end
    taps[0][2] = up;
    taps[1][2] = mid;
    taps[2][2] = px;
    line_rows[ic] = mid;
    line_rows[cv3_pkg::MaxWidth + ic] = px;

    if (ic != 0 && ir >= 1 && ir <= h) convolve_window(ir - 1, ic - 1, 1'b0, 1'b0, w, h);

    if (ic == 0 && ir >= h + 1) begin
      ir = 0;
      ic = 0;
    end else begin
      ic++;
      if (ic >= w) begin
        ic = 0;
        ir++;
      end
    end
    next_col = ic;
    next_row = ir & 32'hFFFF;
  endfunction

  function void check_filter_result(logic [27:0] value, logic [7:0] magnitude, logic last);
    filter_result_t want;

    results_seen++;
    if (results_due.size() == 0) begin
      flag($sformatf("unexpected result: expected none, actual value %0d magnitude %0d last %0b",
                     $signed(value), magnitude, last));
      return;
    end
    want = results_due.pop_front();
    if (value !== want.value)
      flag($sformatf("filtered_value: expected %0d, actual %0d",
                     $signed(want.value), $signed(value)));
    if (magnitude !== want.magnitude)
      flag($sformatf("magnitude: expected %0d, actual %0d", want.magnitude, magnitude));
    if (last !== want.frame_last)
      flag($sformatf("frame_last: expected %0b, actual %0b", want.frame_last, last));
  endfunction

endclass

module conv2d_3x3_reflect_border_unit_tb;

  // Stop the random part after about this many requests
  localparam int unsigned RandomItems   = 1200;
  // Give the pipe and result queue room to empty
  localparam int unsigned SettleCycles  = 16;
  // Cycles without any transfer or register write before the run is abandoned
  localparam int unsigned WatchdogLimit = 2000;
  // Cycles spent in one receiver stall mode before picking one at random again
  localparam int unsigned ReadyModeSpan = 200;
  localparam int          CfgIndexTop   = (1 << $bits(cv3_pkg::cfg_reg_e)) - 1;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_BURSTY
  } ready_mode_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_index_i   = '0;
  logic [47:0] cfg_wdata_i   = '0;

  conv_window_scoreboard sb;
  int unsigned           burst_left = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           ready_count = 0;
  ready_mode_e           ready_mode = READY_ALWAYS;

  conv2d_3x3_reflect_border_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Sample both streams at the rising edge; note the request first so that
  // queue order follows acceptance order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.take_pixel_request(stream_op_e'(s_axis_tuser[0]), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_filter_result(m_axis_tdata[27:0], m_axis_tdata[35:28], m_axis_tlast);
    end
  end

  // Abandon the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no request moved for %0d cycles, giving up", $time, WatchdogLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver back-pressure: switch between always ready, coin flips, rare
  // ready cycles and a fixed repeating pattern of stall and ready cycles.
  always @(negedge clk_i) begin
    if (ready_count % ReadyModeSpan == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
    ready_count++;
    case (ready_mode)
      READY_ALWAYS: m_axis_tready <= 1'b1;
      READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:      m_axis_tready <= (ready_count % 24) >= 16;
    endcase
  end

  // Offer one request and hold it until accepted. Requests go out in bursts
  // of random length; drop valid for a random gap between bursts. Enter and
  // leave at a falling edge.
  task automatic send_request(stream_op_e op, logic [7:0] pixel);
    int unsigned gap;

    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write: one strobe, then a cycle with the strobe low
  task automatic write_cfg(logic [2:0] index, logic [47:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= data;
    sb.write_reg(index, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every owed result, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.results_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_frame(logic [11:0] width, logic [15:0] height,
                               logic [47:0] k_top, logic [47:0] k_mid, logic [47:0] k_bot);
    write_cfg(cv3_pkg::CFG_IMAGE_WIDTH, 48'(width));
    write_cfg(cv3_pkg::CFG_IMAGE_HEIGHT, 48'(height));
    write_cfg(cv3_pkg::CFG_KERNEL_TOP, k_top);
    write_cfg(cv3_pkg::CFG_KERNEL_MIDDLE, k_mid);
    write_cfg(cv3_pkg::CFG_KERNEL_BOTTOM, k_bot);
    // now and then poke an index past the last register; it must be ignored
    if ($urandom_range(0, 5) == 0)
      write_cfg(3'($urandom_range(int'(cv3_pkg::CFG_KERNEL_BOTTOM) + 1, CfgIndexTop)),
                48'({$urandom(), $urandom()}));
  endtask

  // Mostly full-range pixels, some at the extremes, a few drain ticks that
  // stand in for black pixels inside the frame.
  task automatic send_pixels(int unsigned count);
    stream_op_e op;
    logic [7:0] pix;

    repeat (count) begin
      op = stream_op_e'(($urandom_range(0, 15) == 0) ? OP_DRAIN : OP_PIXEL);
      case ($urandom_range(0, 7))
        0:       pix = 8'd0;
        1:       pix = 8'd255;
        default: pix = 8'($urandom);
      endcase
      send_request(op, pix);
    end
  endtask

  // Drain until the predictor is back at the first pixel of a frame. Lead
  // with a pixel request, which past the last row must act as a drain tick.
  task automatic flush_frame();
    bit lead;

    lead = 1'b1;
    while (!sb.at_frame_start()) begin
      send_request(stream_op_e'((lead || $urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN),
                   8'($urandom));
      lead = 1'b0;
    end
  endtask

  // Coefficients: raw random, around +-1.0, at the Q8.8 extremes, or zero
  function automatic logic [47:0] random_kernel_row();
    logic [47:0] row;
    logic [15:0] coef;

    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(0, 3))
        0:       coef = 16'($urandom);
        1:       coef = 16'($urandom_range(0, 512)) - 16'd256;
        2:       coef = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: coef = '0;
      endcase
      row[16*c +: 16] = coef;
    end
    return row;
  endfunction

  initial begin
    int unsigned goal;
    logic [11:0] width;
    logic [15:0] height;

    sb = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest frame under the reset kernel: indexes past the last register
    // get all ones and must change nothing; width 0 and height 1 clamp to 2.
    for (int idx = int'(cv3_pkg::CFG_KERNEL_BOTTOM) + 1; idx <= CfgIndexTop; idx++)
      write_cfg(3'(idx), '1);
    write_cfg(cv3_pkg::CFG_IMAGE_WIDTH, 48'd0);
    write_cfg(cv3_pkg::CFG_IMAGE_HEIGHT, 48'd1);
    send_request(OP_PIXEL, 8'd255);
    send_request(OP_PIXEL, 8'd0);
    send_request(OP_PIXEL, 8'd0);
    send_request(OP_PIXEL, 8'd255);
    flush_frame();
    settle();

    // Most negative coefficients over full-white pixels: most negative sum
    program_frame(12'd2, 16'd2, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
    repeat (4) send_request(OP_PIXEL, 8'd255);
    flush_frame();
    settle();

    // Most positive coefficients, height above the cap, a drain tick inside
    // the frame; then shrink width and height in the middle of the second row
    // so that the row ends early and the rows beyond act as drain rows.
    program_frame(12'd5, 16'hFFFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF);
    repeat (3) send_request(OP_PIXEL, 8'd255);
    send_request(OP_DRAIN, 8'd255);
    repeat (3) send_request(OP_PIXEL, 8'd255);
    settle();
    write_cfg(cv3_pkg::CFG_IMAGE_WIDTH, 48'd2);
    write_cfg(cv3_pkg::CFG_IMAGE_HEIGHT, 48'd1);
    flush_frame();
    settle();

    // Random frames, mostly small, a few with clamped sizes
    goal = sb.requests + RandomItems;
    while (sb.requests < goal) begin
      width  = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1)) : 12'($urandom_range(2, 12));
      height = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(2, 6));
      program_frame(width, height, random_kernel_row(), random_kernel_row(), random_kernel_row());
      send_pixels(sb.frame_width() * sb.frame_height());
      flush_frame();
      settle();
    end

    $display("Streamed %0d requests (%0d drain ticks) through %0d frames; checked %0d results.",
             sb.requests, sb.drain_ticks, sb.frames_done, sb.results_seen);
    $display("Errors found: %0d, results still owed: %0d.", sb.errors, sb.results_due.size());
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> conv2d_3x3_reflect_border_unit.f
rtl/cv3_pkg.sv
rtl/cv3_ram.sv
rtl/cv3_mac.sv
rtl/conv2d_3x3_reflect_border_unit.sv
rtl/cv3_checker.sv
tb/conv2d_3x3_reflect_border_unit_tb.sv
